@@ hw/rtl/mssd_pkg.sv @@
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, codes and the digit glyph table of the meter display driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

	typedef enum logic [2:0] {
		CMD_VOLT   = 3'd0,
		CMD_AMP    = 3'd1,
		CMD_POWER  = 3'd2,
		CMD_ENERGY = 3'd3,
		CMD_SET    = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_code_t;

	localparam logic [1:0] CH_VOLT   = 2'd0;
	localparam logic [1:0] CH_AMP    = 2'd1;
	localparam logic [1:0] CH_POWER  = 2'd2;
	localparam logic [1:0] CH_ENERGY = 2'd3;

	localparam logic [3:0] MODE_MASK_ALL = 4'd3;
	localparam logic [3:0] MODE_KILO     = 4'd8;

	localparam logic [3:0]  BLANK      = 4'd10;
	localparam logic [3:0]  DIGIT_MAX  = 4'd15;
	localparam logic [31:0] DIV10_MUL  = 32'd52429;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  display_mode;
		logic [15:0] value_int;
		logic [6:0]  value_frac;
		logic        kilo_flag;
	} cmd_item_t;

	typedef struct packed {
		logic [5:0] ram_address;
		logic [3:0] ram_nibble;
		logic       last;
		logic       bad_command;
	} wr_item_t;

	typedef struct packed {
		logic            done;
		logic [3:0][3:0] digit;
	} dec_stat_t;

	// abcdefg, a in bit 6; codes of ten and up are blank
	function automatic logic [6:0] glyph(input logic [3:0] code);
		logic [6:0] g;
		unique case (code)
			4'd0:    g = 7'h7E;
			4'd1:    g = 7'h30;
			4'd2:    g = 7'h6D;
			4'd3:    g = 7'h79;
			4'd4:    g = 7'h33;
			4'd5:    g = 7'h5B;
			4'd6:    g = 7'h5F;
			4'd7:    g = 7'h70;
			4'd8:    g = 7'h7F;
			4'd9:    g = 7'h7B;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

endpackage

@@ hw/rtl/mssd_ram.sv @@
// ----------------------------------------------------------------------------
// mssd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mssd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/mssd_dec.sv @@
// ----------------------------------------------------------------------------
// mssd_dec
// Iterative decimal splitter: one digit of a 16-bit value per cycle, four
// digits, by reciprocal multiplication.
// ----------------------------------------------------------------------------
module mssd_dec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         value,
	output mssd_pkg::dec_stat_t stat
);

	import mssd_pkg::*;

	logic            run_q;
	logic            done_q;
	logic [1:0]      idx_q;
	logic [15:0]     x_q;
	logic [3:0][3:0] digit_q;
	logic [31:0]     prod;
	logic [12:0]     quo;
	logic [15:0]     rem;

	assign prod = 32'(x_q) * DIV10_MUL;
	assign quo  = prod[31:19];
	assign rem  = x_q - (16'(quo) * 16'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= run_q && (idx_q == 2'd3);
			if (start) begin
				run_q <= 1'b1;
				idx_q <= '0;
			end else if (run_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= value;
		end else if (run_q) begin
			x_q            <= 16'(quo);
			digit_q[idx_q] <= rem[3:0];
		end
	end

	assign stat.done  = done_q;
	assign stat.digit = digit_q;

endmodule

@@ hw/rtl/meter_seven_segment_display_driver_unit.sv @@
// ----------------------------------------------------------------------------
// meter_seven_segment_display_driver_unit
// Meter panel driver: reading commands update digit stores and flags, then
// stream the whole segment RAM image as nibble writes.
//
// A reading command (voltage, current, power, energy) runs through the cycle
// in which it is taken, the decimal split of the integer part (one digit per
// cycle), up to four writes into the digit memory (one write port), one read
// prefetch, then 32 nibble writes at one per cycle when the sink keeps ready
// high. Set-all and clear-all stream FILL_COUNT nibble writes, an invalid
// command one flagged write. A new command is taken once the previous run has
// been handed to the output register.
// ----------------------------------------------------------------------------
module meter_seven_segment_display_driver_unit #(
	parameter int FILL_COUNT = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  mssd_pkg::cmd_item_t  cmd_item,
	output logic                 wr_valid,
	input  logic                 wr_ready,
	output mssd_pkg::wr_item_t   wr_item
);

	import mssd_pkg::*;

	localparam logic [5:0] FILL_LAST = 6'(FILL_COUNT - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CONV  = 7'b0000010,
		ST_WRITE = 7'b0000100,
		ST_PREF  = 7'b0001000,
		ST_EMIT  = 7'b0010000,
		ST_FILL  = 7'b0100000,
		ST_BAD   = 7'b1000000
	} state_t;

	state_t          state_q;
	cmd_item_t       item_q;
	wr_item_t        out_q;
	logic            out_valid_q;
	logic [1:0]      widx_q;
	logic [4:0]      emit_q;
	logic [5:0]      fill_q;
	logic [15:0]     vld_q;
	logic            rd_vld_q;
	logic [2:0]      point_q;
	logic [1:0]      kilo_q;
	logic [3:0]      label_q;
	logic [3:0]      unit_q;

	dec_stat_t       dec_stat;
	logic            dec_start;
	logic            load;
	logic            out_load;
	logic [1:0]      ch;
	logic [3:0]      mode;
	logic [15:0]     v;
	logic [6:0]      f;
	logic            v_gt99;
	logic            v_gt999;
	logic            v_lt10;
	logic            v_lt100;
	logic            v_lt1000;
	logic [6:0]      fm;
	logic [14:0]     fprod;
	logic [3:0]      ft;
	logic [6:0]      fo_w;
	logic [3:0]      fo;
	logic            dot;
	logic [3:0][3:0] new_d;
	logic            ram_we;
	logic [3:0]      ram_waddr;
	logic            ram_re;
	logic [3:0]      ram_raddr;
	logic [3:0]      ram_rdata;
	logic [3:0]      pos;
	logic [3:0]      pos_next;
	logic [3:0]      cur_digit;
	logic [6:0]      g;
	logic            flag;
	logic [3:0]      n0;
	logic [3:0]      n1;

	assign cmd_ready = (state_q == ST_IDLE);
	assign dec_start = cmd_ready && cmd_valid && (cmd_item.cmd[2] == 1'b0);
	assign load      = !out_valid_q || wr_ready;
	assign out_load  = load && ((state_q == ST_EMIT) || (state_q == ST_FILL) ||
	                            (state_q == ST_BAD));

	mssd_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.value  (cmd_item.value_int),
		.stat   (dec_stat)
	);

	assign ch       = item_q.cmd[1:0];
	assign mode     = item_q.display_mode;
	assign v        = item_q.value_int;
	assign f        = item_q.value_frac;
	assign v_gt99   = v > 16'd99;
	assign v_gt999  = v > 16'd999;
	assign v_lt10   = v < 16'd10;
	assign v_lt100  = v < 16'd100;
	assign v_lt1000 = v < 16'd1000;

	assign fm    = (f >= 7'd100) ? f - 7'd100 : f;
	assign fprod = 15'(fm) * 15'd205;
	assign ft    = fprod[14:11];
	assign fo_w  = fm - (7'(ft) * 7'd10);
	assign fo    = fo_w[3:0];

	always_comb begin
		new_d = {BLANK, BLANK, BLANK, BLANK};
		dot   = 1'b0;
		if (mode > MODE_MASK_ALL) begin
			new_d = {4{(v > 16'(DIGIT_MAX)) ? DIGIT_MAX : v[3:0]}};
		end else if (!mode[0]) begin
			case (ch)
				CH_VOLT, CH_AMP: begin
					if (v_gt99) begin
						new_d[3] = v_lt1000 ? BLANK : dec_stat.digit[3];
						new_d[2] = dec_stat.digit[2];
						new_d[1] = dec_stat.digit[1];
						new_d[0] = dec_stat.digit[0];
					end else begin
						dot      = 1'b1;
						new_d[3] = v_lt10 ? BLANK : dec_stat.digit[1];
						new_d[2] = dec_stat.digit[0];
						if (f > 7'd9) begin
							new_d[1] = ft;
							new_d[0] = fo;
						end else begin
							new_d[1] = f[3:0];
							new_d[0] = BLANK;
						end
					end
				end
				CH_POWER: begin
					if (v_gt999) begin
						new_d = dec_stat.digit;
					end else begin
						dot      = 1'b1;
						new_d[3] = v_lt100 ? BLANK : dec_stat.digit[2];
						new_d[2] = v_lt10 ? BLANK : dec_stat.digit[1];
						new_d[1] = dec_stat.digit[0];
						new_d[0] = fo;
					end
				end
				default: begin
					new_d[3] = v_lt1000 ? BLANK : dec_stat.digit[3];
					new_d[2] = v_lt100 ? BLANK : dec_stat.digit[2];
					new_d[1] = v_lt10 ? BLANK : dec_stat.digit[1];
					new_d[0] = dec_stat.digit[0];
				end
			endcase
		end
	end

	assign ram_we    = (state_q == ST_WRITE) &&
	                   ((mode <= MODE_MASK_ALL) ||
	                    ((mode[3:2] == 2'b01) && (mode[1:0] == widx_q)));
	assign ram_waddr = {ch, widx_q};

	assign pos       = emit_q[4:1];
	assign pos_next  = (state_q == ST_PREF) ? 4'd0 : pos + 4'd1;
	assign ram_re    = (state_q == ST_PREF) || ((state_q == ST_EMIT) && load && emit_q[0]);
	assign ram_raddr = {pos_next[3:2], ~pos_next[1:0]};

	mssd_ram #(
		.WIDTH (4),
		.DEPTH (16)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (new_d[widx_q]),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign cur_digit = rd_vld_q ? ram_rdata : 4'd0;
	assign g         = glyph(cur_digit);

	always_comb begin
		unique case (pos)
			4'd0:    flag = label_q[0];
			4'd1:    flag = point_q[0];
			4'd3:    flag = unit_q[0];
			4'd4:    flag = label_q[1];
			4'd5:    flag = point_q[1];
			4'd7:    flag = unit_q[1];
			4'd9:    flag = label_q[2];
			4'd10:   flag = point_q[2];
			4'd11:   flag = label_q[3];
			4'd12:   flag = unit_q[2];
			4'd13:   flag = kilo_q[0];
			4'd14:   flag = unit_q[3];
			4'd15:   flag = kilo_q[1];
			default: flag = 1'b0;
		endcase
	end

	always_comb begin
		if (!pos[3]) begin
			n0 = {g[6], g[1], g[2], g[3]};
			n1 = {g[5], g[0], g[4], flag};
		end else begin
			n0 = {g[3], g[2], g[1], g[6]};
			n1 = {flag, g[4], g[0], g[5]};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			widx_q      <= '0;
			emit_q      <= '0;
			fill_q      <= '0;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			point_q     <= '0;
			kilo_q      <= '0;
			label_q     <= '0;
			unit_q      <= '0;
		end else begin
			if (wr_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_vld_q <= vld_q[ram_raddr];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						fill_q <= '0;
						if (cmd_item.cmd[2] == 1'b0) begin
							state_q <= ST_CONV;
						end else if ((cmd_item.cmd == CMD_SET) ||
						             (cmd_item.cmd == CMD_CLEAR)) begin
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_BAD;
						end
					end
				end
				ST_CONV: begin
					if (dec_stat.done) begin
						state_q <= ST_WRITE;
						widx_q  <= '0;
						if (mode <= MODE_MASK_ALL) begin
							label_q[ch] <= !mode[1];
							unit_q[ch]  <= !mode[1];
							if (ch[1]) begin
								kilo_q[ch[0]] <= !mode[0] && item_q.kilo_flag;
							end
							if (ch != CH_ENERGY) begin
								point_q[ch] <= !mode[0] && dot;
							end
						end else if ((mode == MODE_KILO) && ch[1]) begin
							kilo_q[ch[0]] <= item_q.kilo_flag;
						end
					end
				end
				ST_WRITE: begin
					widx_q <= widx_q + 2'd1;
					if (widx_q == 2'd3) begin
						state_q <= ST_PREF;
					end
				end
				ST_PREF: begin
					state_q <= ST_EMIT;
					emit_q  <= '0;
				end
				ST_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						emit_q      <= emit_q + 5'd1;
						if (emit_q == 5'd31) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FILL: begin
					if (load) begin
						out_valid_q <= 1'b1;
						fill_q      <= fill_q + 6'd1;
						if (fill_q == FILL_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BAD: begin
					if (load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			item_q <= cmd_item;
		end
		if (load) begin
			if (state_q == ST_EMIT) begin
				out_q.ram_address <= {emit_q, 1'b0} >> 1 == 6'd0 ? 6'(emit_q) : 6'(emit_q);
				out_q.ram_nibble  <= emit_q[0] ? n1 : n0;
				out_q.last        <= (emit_q == 5'd31);
				out_q.bad_command <= 1'b0;
			end else if (state_q == ST_FILL) begin
				out_q.ram_address <= fill_q;
				out_q.ram_nibble  <= (item_q.cmd == CMD_SET) ? 4'hF : 4'h0;
				out_q.last        <= (fill_q == FILL_LAST);
				out_q.bad_command <= 1'b0;
			end else if (state_q == ST_BAD) begin
				out_q.ram_address <= '0;
				out_q.ram_nibble  <= '0;
				out_q.last        <= 1'b1;
				out_q.bad_command <= 1'b1;
			end
		end
	end

	assign wr_valid = out_valid_q;
	assign wr_item  = out_q;

	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_item.bad_command |-> wr_item.last && (wr_item.ram_address == 6'd0))
		else $error("invalid-command transfer is not a single write at address zero");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_ready && !wr_item.last |=> wr_valid)
		else $error("write run stalled after a transfer that was not last");

	a_dec_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dec_stat.done |-> (state_q == ST_CONV))
		else $error("decimal split finished outside conversion");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while a run is starting");

endmodule

@@ tb/sv/tb_meter_seven_segment_display_driver_unit.sv @@
// ----------------------------------------------------------------------------
// tb_meter_seven_segment_display_driver_unit
// Drives reading, fill and invalid commands into the meter panel driver. A
// scoreboard tracks the digit stores and flags, renders the expected segment
// RAM writes for every command taken, and compares each write coming out of
// the block field by field. Both sides idle at random. The write side holds
// off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_meter_seven_segment_display_driver_unit;

	import mssd_pkg::*;

	localparam int FILL_COUNT      = 63;
	localparam int RESET_CYCLES    = 7;
	localparam int IDLE_LIMIT      = 5000;
	localparam int DRAIN_CYCLES    = 150;
	localparam int RANDOM_ITEMS    = 94;
	localparam int PRESSURE_AT     = 300;
	localparam int PRESSURE_CYCLES = 400;
	localparam int QUIET_FIRST     = 40;
	localparam int QUIET_LAST      = 70;

	localparam logic [2:0] CMD_BAD_LO = 3'd6;
	localparam logic [2:0] CMD_BAD_HI = 3'd7;

	localparam logic [3:0] MODE_NORMAL    = 4'd0;
	localparam logic [3:0] MODE_MASK_NUM  = 4'd1;
	localparam logic [3:0] MODE_MASK_TEXT = 4'd2;
	localparam logic [3:0] MODE_DIGIT1    = 4'd4;
	localparam logic [3:0] MODE_DIGIT2    = 4'd5;
	localparam logic [3:0] MODE_DIGIT3    = 4'd6;
	localparam logic [3:0] MODE_DIGIT4    = 4'd7;
	localparam logic [3:0] MODE_SPARE_LO  = 4'd9;
	localparam logic [3:0] MODE_SPARE_HI  = 4'd15;

	// abcdefg per digit code, codes ten and up blank
	localparam logic [15:0][6:0] SEG_OF = {
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h7B, 7'h7F, 7'h70, 7'h5F, 7'h5B, 7'h33, 7'h79, 7'h6D, 7'h30, 7'h7E
	};

	class display_scoreboard;
		wr_item_t   pending_writes[$];
		logic [3:0] digits[4][4];
		logic [2:0] point_flags;
		logic [1:0] kilo_marks;
		logic [3:0] label_marks;
		logic [3:0] unit_marks;
		int         errors;
		int         n_cmds;
		int         n_fill;
		int         n_bad;
		int         n_writes;

		function new();
			foreach (digits[i, j])
				digits[i][j] = '0;
			point_flags = '0;
			kilo_marks  = '0;
			label_marks = '0;
			unit_marks  = '0;
			errors      = 0;
			n_cmds      = 0;
			n_fill      = 0;
			n_bad       = 0;
			n_writes    = 0;
		endfunction

		function void note_command(cmd_item_t c);
			int unsigned v;
			int unsigned f;
			int          ch;
			bit          dot;
			logic [15:0] flag;
			logic [6:0]  g;
			logic [3:0]  n0;
			logic [3:0]  n1;
			wr_item_t    w;

			n_cmds++;
			v = 32'(c.value_int);
			f = 32'(c.value_frac);
			ch = int'(c.cmd);
			if (c.cmd >= CMD_BAD_LO) begin
				n_bad++;
				w.ram_address = '0;
				w.ram_nibble  = '0;
				w.last        = 1'b1;
				w.bad_command = 1'b1;
				pending_writes.push_back(w);
				return;
			end
			if (c.cmd == CMD_SET || c.cmd == CMD_CLEAR) begin
				n_fill++;
				for (int p = 0; p < FILL_COUNT; p++) begin
					w.ram_address = 6'(p);
					w.ram_nibble  = (c.cmd == CMD_SET) ? 4'hF : 4'h0;
					w.last        = (p == FILL_COUNT - 1);
					w.bad_command = 1'b0;
					pending_writes.push_back(w);
				end
				return;
			end

			if (c.display_mode <= MODE_MASK_ALL) begin
				dot = 1'b0;
				label_marks[ch] = !c.display_mode[1];
				unit_marks[ch]  = !c.display_mode[1];
				if (c.display_mode[0]) begin
					for (int i = 0; i < 4; i++)
						digits[ch][i] = BLANK;
					if (ch >= CH_POWER)
						kilo_marks[ch - 2] = 1'b0;
				end else begin
					if (ch >= CH_POWER)
						kilo_marks[ch - 2] = c.kilo_flag;
					case (ch)
						CH_VOLT, CH_AMP: begin
							if (v > 99) begin
								digits[ch][3] = (v < 1000) ? BLANK : 4'((v % 10000) / 1000);
								digits[ch][2] = 4'((v % 1000) / 100);
								digits[ch][1] = 4'((v % 100) / 10);
								digits[ch][0] = 4'(v % 10);
							end else begin
								dot = 1'b1;
								digits[ch][3] = (v < 10) ? BLANK : 4'(v / 10);
								digits[ch][2] = 4'(v % 10);
								if (f > 9) begin
									digits[ch][1] = 4'((f % 100) / 10);
									digits[ch][0] = 4'(f % 10);
								end else begin
									digits[ch][1] = 4'(f);
									digits[ch][0] = BLANK;
								end
							end
						end
						CH_POWER: begin
							if (v > 999) begin
								digits[ch][3] = 4'((v % 10000) / 1000);
								digits[ch][2] = 4'((v % 1000) / 100);
								digits[ch][1] = 4'((v % 100) / 10);
								digits[ch][0] = 4'(v % 10);
							end else begin
								dot = 1'b1;
								digits[ch][3] = (v < 100) ? BLANK : 4'(v / 100);
								digits[ch][2] = (v < 10) ? BLANK : 4'((v % 100) / 10);
								digits[ch][1] = 4'(v % 10);
								digits[ch][0] = 4'(f % 10);
							end
						end
						default: begin
							digits[ch][3] = (v < 1000) ? BLANK : 4'((v % 10000) / 1000);
							digits[ch][2] = (v < 100) ? BLANK : 4'((v % 1000) / 100);
							digits[ch][1] = (v < 10) ? BLANK : 4'((v % 100) / 10);
							digits[ch][0] = 4'(v % 10);
						end
					endcase
				end
				if (ch < CH_ENERGY)
					point_flags[ch] = dot;
			end else if (c.display_mode <= MODE_DIGIT4) begin
				digits[ch][c.display_mode - MODE_DIGIT1] = (v > 15) ? DIGIT_MAX : v[3:0];
			end else if (c.display_mode == MODE_KILO && ch >= CH_POWER) begin
				kilo_marks[ch - 2] = c.kilo_flag;
			end

			flag = {kilo_marks[1], unit_marks[3], kilo_marks[0], unit_marks[2],
				label_marks[3], point_flags[2], label_marks[2], 1'b0,
				unit_marks[1], 1'b0, point_flags[1], label_marks[1],
				unit_marks[0], 1'b0, point_flags[0], label_marks[0]};
			for (int p = 0; p < 16; p++) begin
				g = SEG_OF[digits[p / 4][3 - p % 4]];
				if (p < 8) begin
					n0 = {g[6], g[1], g[2], g[3]};
					n1 = {g[5], g[0], g[4], flag[p]};
				end else begin
					n0 = {g[3], g[2], g[1], g[6]};
					n1 = {flag[p], g[4], g[0], g[5]};
				end
				w.ram_address = 6'(2 * p);
				w.ram_nibble  = n0;
				w.last        = 1'b0;
				w.bad_command = 1'b0;
				pending_writes.push_back(w);
				w.ram_address = 6'(2 * p + 1);
				w.ram_nibble  = n1;
				w.last        = (p == 15);
				pending_writes.push_back(w);
			end
		endfunction

		function void check_write(wr_item_t got);
			wr_item_t want;

			n_writes++;
			if (pending_writes.size() == 0) begin
				$error("unexpected write: address %0d nibble %0h last %0b bad %0b",
					got.ram_address, got.ram_nibble, got.last, got.bad_command);
				errors++;
				return;
			end
			want = pending_writes.pop_front();
			if (got.ram_address !== want.ram_address) begin
				$error("ram_address: expected %0d, got %0d", want.ram_address, got.ram_address);
				errors++;
			end
			if (got.ram_nibble !== want.ram_nibble) begin
				$error("ram_nibble: expected %0h, got %0h", want.ram_nibble, got.ram_nibble);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
			if (got.bad_command !== want.bad_command) begin
				$error("bad_command: expected %0b, got %0b", want.bad_command, got.bad_command);
				errors++;
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	cmd_item_t cmd_item  = '0;
	logic      wr_ready  = 1'b0;
	logic      cmd_ready;
	logic      wr_valid;
	wr_item_t  wr_item;
	bit        quiet     = 1'b0;

	display_scoreboard sb = new();

	always #10 clk = ~clk;

	meter_seven_segment_display_driver_unit #(
		.FILL_COUNT(FILL_COUNT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_item (cmd_item),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_item  (wr_item)
	);

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic cmd_item_t make_cmd(logic [2:0] cmd, logic [3:0] mode,
		logic [15:0] v, logic [6:0] f, logic k);
		cmd_item_t it;

		it.cmd          = cmd;
		it.display_mode = mode;
		it.value_int    = v;
		it.value_frac   = f;
		it.kilo_flag    = k;
		return it;
	endfunction

	function automatic cmd_item_t random_cmd();
		int unsigned r;
		int unsigned m;
		cmd_item_t   it;

		r = $urandom_range(0, 99);
		if (r < 80)
			it.cmd = 3'($urandom_range(CMD_VOLT, CMD_ENERGY));
		else if (r < 92)
			it.cmd = r[0] ? CMD_SET : CMD_CLEAR;
		else
			it.cmd = r[0] ? CMD_BAD_HI : CMD_BAD_LO;
		m = $urandom_range(0, 99);
		if (m < 45)
			it.display_mode = MODE_NORMAL;
		else if (m < 60)
			it.display_mode = 4'($urandom_range(MODE_MASK_NUM, MODE_MASK_ALL));
		else if (m < 80)
			it.display_mode = 4'($urandom_range(MODE_DIGIT1, MODE_DIGIT4));
		else if (m < 90)
			it.display_mode = MODE_KILO;
		else
			it.display_mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		case ($urandom_range(0, 3))
			0:       it.value_int = 16'($urandom_range(0, 15));
			1:       it.value_int = 16'($urandom_range(0, 999));
			2:       it.value_int = 16'($urandom_range(0, 9999));
			default: it.value_int = 16'($urandom_range(0, 65535));
		endcase
		it.value_frac = 7'($urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(0, 127));
		it.kilo_flag  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	initial begin : write_sink
		int stall;
		bit held;

		held = 1'b0;
		forever begin
			if (!held && sb.n_writes >= PRESSURE_AT) begin
				held = 1'b1;
				wr_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else begin
				stall = draw_wait();
				if (stall > 0) begin
					wr_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			wr_ready <= 1'b1;
			do @(posedge clk); while (wr_valid !== 1'b1);
			sb.check_write(wr_item);
		end
	end

	initial begin : watchdog
		int idle;

		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (wr_valid && wr_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_meter_seven_segment_display_driver_unit: FAIL");
		$finish;
	end

	initial begin : stimulus
		cmd_item_t plan[$];
		int        gap;

		plan.push_back(make_cmd(CMD_VOLT, MODE_NORMAL, 16'd0, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_VOLT, MODE_NORMAL, 16'd99, 7'd99, 1'b1));
		plan.push_back(make_cmd(CMD_AMP, MODE_NORMAL, 16'd9, 7'd9, 1'b0));
		plan.push_back(make_cmd(CMD_AMP, MODE_NORMAL, 16'd100, 7'd127, 1'b1));
		plan.push_back(make_cmd(CMD_VOLT, MODE_NORMAL, 16'hFFFF, 7'd127, 1'b1));
		plan.push_back(make_cmd(CMD_POWER, MODE_NORMAL, 16'd999, 7'd127, 1'b1));
		plan.push_back(make_cmd(CMD_POWER, MODE_NORMAL, 16'd1000, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_POWER, MODE_NORMAL, 16'd5, 7'd7, 1'b1));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_NORMAL, 16'd9999, 7'd0, 1'b1));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_NORMAL, 16'd12345, 7'd50, 1'b0));
		plan.push_back(make_cmd(CMD_VOLT, MODE_MASK_NUM, 16'd42, 7'd1, 1'b0));
		plan.push_back(make_cmd(CMD_POWER, MODE_MASK_TEXT, 16'd321, 7'd4, 1'b1));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_MASK_ALL, 16'd77, 7'd0, 1'b1));
		plan.push_back(make_cmd(CMD_VOLT, MODE_DIGIT1, 16'd9, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_AMP, MODE_DIGIT4, 16'd10, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_POWER, MODE_DIGIT2, 16'hFFFF, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_DIGIT3, 16'd15, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_VOLT, MODE_KILO, 16'd3, 7'd3, 1'b1));
		plan.push_back(make_cmd(CMD_POWER, MODE_KILO, 16'd0, 7'd0, 1'b1));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_KILO, 16'd0, 7'd0, 1'b1));
		plan.push_back(make_cmd(CMD_AMP, MODE_SPARE_LO, 16'd55, 7'd5, 1'b1));
		plan.push_back(make_cmd(CMD_ENERGY, MODE_SPARE_HI, 16'd8, 7'd8, 1'b0));
		plan.push_back(make_cmd(CMD_SET, MODE_NORMAL, 16'd0, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_CLEAR, MODE_NORMAL, 16'd0, 7'd0, 1'b0));
		plan.push_back(make_cmd(CMD_BAD_LO, MODE_NORMAL, 16'd1, 7'd1, 1'b1));
		plan.push_back(make_cmd(CMD_BAD_HI, MODE_SPARE_HI, 16'hFFFF, 7'd127, 1'b1));
		repeat (RANDOM_ITEMS)
			plan.push_back(random_cmd());

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
			gap = draw_wait();
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			cmd_valid <= 1'b1;
			cmd_item  <= plan[i];
			do @(posedge clk); while (!cmd_ready);
			sb.note_command(plan[i]);
		end
		cmd_valid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands (%0d fill, %0d invalid), checked %0d segment RAM writes.",
			sb.n_cmds, sb.n_fill, sb.n_bad, sb.n_writes);
		$display("Mismatches: %0d", sb.errors);
		if (sb.errors == 0)
			$display("tb_meter_seven_segment_display_driver_unit: PASS");
		else
			$display("tb_meter_seven_segment_display_driver_unit: FAIL");
		$finish;
	end

endmodule
